[rtl/core/ssp_pkg.sv]
package ssp_pkg;

  // number of servos and field widths
  localparam int SERVO_COUNT = 4;
  localparam int POS_W       = 15;
  localparam int STEP_W      = 15;
  localparam int SLOT_W      = 16;
  localparam int IDX_W       = 2;
  localparam int STEP_REGS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // derived control widths
  localparam int PTR_W       = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int FRAME_EDGES = 2 * SERVO_COUNT;
  localparam int EDGE_W      = $clog2(FRAME_EDGES);

  // state row memory: one row holds every servo
  localparam int ROW_DEPTH   = 2;
  localparam int ROW_AW      = 1;
  localparam logic [ROW_AW-1:0] ROW_ADDR = '0;

  // reset values
  localparam logic [POS_W-1:0]  RESET_POSITION = 15'd1500;
  localparam logic [SLOT_W-1:0] SLOT_RESET     = 16'd5000;
  localparam logic [STEP_REGS-1:0][STEP_W-1:0] SLEW_RESET =
    {15'd40, 15'd20, 15'd5, 15'd500};

  // opcodes
  localparam logic OP_TICK       = 1'b0;
  localparam logic OP_SET_TARGET = 1'b1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLEW_0      = 3'd0,
    REG_SLEW_1      = 3'd1,
    REG_SLEW_2      = 3'd2,
    REG_SLEW_3      = 3'd3,
    REG_SLOT_PERIOD = 3'd4
  } cfg_reg_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef pos_t [SERVO_COUNT-1:0] pos_row_t;
  typedef logic [STEP_REGS-1:0][STEP_W-1:0] step_bank_t;

  typedef struct packed {
    pos_row_t tgt;
    pos_row_t pos;
  } state_row_t;

  // frame sequencing state
  typedef struct packed {
    logic              low_phase;
    logic [PTR_W-1:0]  pointer;
    logic [EDGE_W-1:0] edge_count;
  } seq_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] servo_select;
    logic [POS_W-1:0] target_position;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  servo_index;
    logic              pin_level;
    logic [SLOT_W-1:0] next_compare;
    logic              frame_done;
  } out_word_t;

  function automatic state_row_t reset_row();
    state_row_t r;
    for (int i = 0; i < SERVO_COUNT; i++) begin
      r.pos[i] = RESET_POSITION;
      r.tgt[i] = RESET_POSITION;
    end
    return r;
  endfunction

endpackage

[rtl/core/ssp_ram.sv]
module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ssp_slew.sv]
module ssp_slew (
  input  ssp_pkg::state_row_t row_in,
  input  ssp_pkg::step_bank_t steps,
  output ssp_pkg::pos_row_t   pos_out
);
  import ssp_pkg::*;

  // one slew lane per servo
  for (genvar g = 0; g < SERVO_COUNT; g++) begin : g_lane
    localparam int LANE_STEP = g % STEP_REGS;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] tgt;
    logic [POS_W-1:0] step;
    logic [POS_W-1:0] dist_dn;
    logic [POS_W-1:0] dist_up;

    assign cur     = row_in.pos[g];
    assign tgt     = row_in.tgt[g];
    assign step    = steps[LANE_STEP];
    assign dist_dn = cur - tgt;
    assign dist_up = tgt - cur;

    // move toward target, close a short gap in one move
    always_comb begin
      if (cur > tgt) begin
        pos_out[g] = (dist_dn > step) ? cur - step : tgt;
      end else if (cur < tgt) begin
        pos_out[g] = (dist_up > step) ? cur + step : tgt;
      end else begin
        pos_out[g] = cur;
      end
    end
  end

endmodule

[rtl/core/ssp_edge.sv]
module ssp_edge (
  input  ssp_pkg::pos_row_t            pos,
  input  logic [ssp_pkg::SLOT_W-1:0]   slot_period,
  input  ssp_pkg::seq_t                seq,
  output ssp_pkg::seq_t                seq_nxt,
  output ssp_pkg::out_word_t           word
);
  import ssp_pkg::*;

  logic [PTR_W-1:0]  sel;
  logic [POS_W-1:0]  pos_sel;
  logic [SLOT_W-1:0] pos_ext;
  logic [EDGE_W:0]   edge_inc;
  logic              done;

  // servo in turn, out-of-range pointer falls back to servo 0
  assign sel = (int'(seq.pointer) < SERVO_COUNT) ? seq.pointer : '0;

  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < SERVO_COUNT; i++) begin
      if (int'(sel) == i) begin
        pos_sel = pos[i];
      end
    end
  end

  assign pos_ext  = {{(SLOT_W-POS_W){1'b0}}, pos_sel};
  assign edge_inc = {1'b0, seq.edge_count} + (EDGE_W+1)'(1);
  assign done     = (int'(edge_inc) >= FRAME_EDGES);

  // edge value and next frame position
  always_comb begin
    seq_nxt = seq;
    word.servo_index = IDX_W'(sel);
    word.frame_done  = done;
    if (!seq.low_phase) begin
      word.pin_level    = 1'b1;
      word.next_compare = pos_ext;
      seq_nxt.low_phase = 1'b1;
    end else begin
      word.pin_level    = 1'b0;
      word.next_compare = (slot_period > pos_ext) ? slot_period - pos_ext : '0;
      seq_nxt.low_phase = 1'b0;
      seq_nxt.pointer   = sel + PTR_W'(1);
    end
    seq_nxt.edge_count = edge_inc[EDGE_W-1:0];
    if (done) begin
      seq_nxt.edge_count = '0;
      seq_nxt.pointer    = '0;
      seq_nxt.low_phase  = 1'b0;
    end
  end

endmodule

[rtl/core/servo_slew_pwm_multiplexer.sv]
// Throughput: one word per cycle unless a full output stalls; a set-target
// word gives no result, a tick word passes the input and output registers.
// Positions and targets of all servos sit in one row of a state memory,
// read on a registered port and forwarded when the previous word wrote it.
// Reset (rst_n low, synchronous) restores registers, positions, targets and
// the frame sequence at once: the memory row reads as reset until written.
module servo_slew_pwm_multiplexer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ssp_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ssp_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ssp_pkg::*;

  step_bank_t        steps_r;
  logic [SLOT_W-1:0] slot_r;
  logic              s1_valid_r;
  in_word_t          s1_word_r;
  logic              fwd_r;
  state_row_t        fwd_row_r;
  logic              row_valid_r;
  seq_t              seq_r;
  seq_t              seq_nxt;
  logic              out_valid_r;
  out_word_t         out_data_r;
  state_row_t        ram_rdata;
  state_row_t        row_cur;
  state_row_t        row_wr;
  pos_row_t          pos_new;
  out_word_t         edge_word;
  logic              is_set;
  logic              fire;
  logic              accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= SLEW_RESET;
      slot_r  <= SLOT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLEW_0:      steps_r[0] <= cfg_wdata[STEP_W-1:0];
        REG_SLEW_1:      steps_r[1] <= cfg_wdata[STEP_W-1:0];
        REG_SLEW_2:      steps_r[2] <= cfg_wdata[STEP_W-1:0];
        REG_SLEW_3:      steps_r[3] <= cfg_wdata[STEP_W-1:0];
        REG_SLOT_PERIOD: slot_r     <= cfg_wdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage one waits only for a full, stalled output word
  assign is_set   = (s1_word_r.opcode == OP_SET_TARGET);
  assign fire     = s1_valid_r && (is_set || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_data;
    end
  end

  // state row memory
  ssp_ram #(
    .WIDTH($bits(state_row_t)),
    .DEPTH(ROW_DEPTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (fire),
    .waddr(ROW_ADDR),
    .wdata(row_wr),
    .raddr(ROW_ADDR),
    .rdata(ram_rdata)
  );

  // forward a row written on the edge that captured the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= 1'b0;
      row_valid_r <= 1'b0;
    end else begin
      fwd_r <= fire;
      if (fire) begin
        row_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_row_r <= row_wr;
    end
  end

  always_comb begin
    if (fwd_r) begin
      row_cur = fwd_row_r;
    end else if (row_valid_r) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = reset_row();
    end
  end

  ssp_slew u_slew (
    .row_in (row_cur),
    .steps  (steps_r),
    .pos_out(pos_new)
  );

  // modified row: new target or slewed positions
  always_comb begin
    row_wr = row_cur;
    if (is_set) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (int'(s1_word_r.servo_select) == i) begin
          row_wr.tgt[i] = s1_word_r.target_position;
        end
      end
    end else begin
      row_wr.pos = pos_new;
    end
  end

  ssp_edge u_edge (
    .pos        (pos_new),
    .slot_period(slot_r),
    .seq        (seq_r),
    .seq_nxt    (seq_nxt),
    .word       (edge_word)
  );

  // frame sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (fire && !is_set) begin
      seq_r <= seq_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && !is_set) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_set) begin
      out_data_r <= edge_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/ssp_checker.sv]
module ssp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ssp_pkg::out_word_t out_data
);
  import ssp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // input backs up only behind a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // frame end only on a low edge
  a_frame_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.pin_level)
    else $error("frame end on a high edge");

  // high time is a position and fits its width
  a_high_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pin_level |-> !out_data.next_compare[SLOT_W-1])
    else $error("high time beyond position range");

endmodule

bind servo_slew_pwm_multiplexer ssp_checker u_ssp_checker (.*);

[tb/servo_slew_pwm_multiplexer_tb.sv]
module servo_slew_pwm_multiplexer_tb;
  import ssp_pkg::*;

  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 300;
  localparam int PHASES         = 6;
  localparam int DRAIN_CYCLES   = 6;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // tracks servo positions and the frame sequence, queues the pulse words due
  class pulse_tracker;
    pos_t              position[SERVO_COUNT];
    pos_t              target[SERVO_COUNT];
    logic [STEP_W-1:0] slew[STEP_REGS];
    logic [SLOT_W-1:0] slot;
    bit                low_phase;
    int unsigned       pointer;
    int unsigned       edge_cnt;
    int                errors;
    out_word_t         pending_pulses[$];

    function new();
      for (int i = 0; i < STEP_REGS; i++) slew[i] = SLEW_RESET[i];
      for (int i = 0; i < SERVO_COUNT; i++) begin
        position[i] = RESET_POSITION;
        target[i]   = RESET_POSITION;
      end
      slot      = SLOT_RESET;
      low_phase = 1'b0;
      pointer   = 0;
      edge_cnt  = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SLEW_0, REG_SLEW_1, REG_SLEW_2, REG_SLEW_3: begin
          slew[idx[1:0]] = data[STEP_W-1:0];
        end
        REG_SLOT_PERIOD: begin
          slot = data;
        end
        default: ;
      endcase
    endfunction

    // move one position toward its target by at most the slew step
    function pos_t slew_toward(pos_t cur, pos_t tgt, logic [STEP_W-1:0] step);
      if (cur > tgt) return (cur - tgt > step) ? cur - step : tgt;
      if (cur < tgt) return (tgt - cur > step) ? cur + step : tgt;
      return cur;
    endfunction

    function void note_word(in_word_t w);
      out_word_t   r;
      int unsigned sel;
      pos_t        p;
      if (w.opcode == OP_SET_TARGET) begin
        if (w.servo_select < SERVO_COUNT) target[w.servo_select] = w.target_position;
        return;
      end
      for (int i = 0; i < SERVO_COUNT; i++)
        position[i] = slew_toward(position[i], target[i], slew[i % STEP_REGS]);
      sel = (pointer < SERVO_COUNT) ? pointer : 0;
      p   = position[sel];
      r.servo_index = IDX_W'(sel);
      if (!low_phase) begin
        r.pin_level    = 1'b1;
        r.next_compare = SLOT_W'(p);
        low_phase      = 1'b1;
      end else begin
        // low time saturates when the position overruns the slot
        r.pin_level    = 1'b0;
        r.next_compare = (slot > p) ? slot - SLOT_W'(p) : '0;
        low_phase      = 1'b0;
        pointer        = sel + 1;
      end
      r.frame_done = 1'b0;
      edge_cnt++;
      if (edge_cnt >= 2 * SERVO_COUNT) begin
        edge_cnt     = 0;
        pointer      = 0;
        low_phase    = 1'b0;
        r.frame_done = 1'b1;
      end
      pending_pulses.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected pulse word idx=%0d lvl=%0d cmp=%0d done=%0d", $time,
                 got.servo_index, got.pin_level, got.next_compare, got.frame_done);
        errors++;
        return;
      end
      want = pending_pulses.pop_front();
      if (got.servo_index !== want.servo_index || got.pin_level !== want.pin_level ||
          got.next_compare !== want.next_compare || got.frame_done !== want.frame_done) begin
        $display("%0t: pulse mismatch expected idx=%0d lvl=%0d cmp=%0d done=%0d,",
                 $time, want.servo_index, want.pin_level, want.next_compare,
                 want.frame_done);
        $display("%0t:   got idx=%0d lvl=%0d cmp=%0d done=%0d",
                 $time, got.servo_index, got.pin_level, got.next_compare,
                 got.frame_done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pulse_tracker sb;
  int send_pct  = 0;
  int recv_pct  = 0;
  bit hold_go   = 1'b0;
  int hold_left = 0;
  int quiet     = 0;

  servo_slew_pwm_multiplexer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_go = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_word_t tick_word();
    in_word_t w;
    w.opcode          = OP_TICK;
    w.servo_select    = '1;
    w.target_position = '1;
    return w;
  endfunction

  function automatic in_word_t target_word(logic [IDX_W-1:0] sel, pos_t pos);
    in_word_t w;
    w.opcode          = OP_SET_TARGET;
    w.servo_select    = sel;
    w.target_position = pos;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    w.opcode       = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_SET_TARGET;
    w.servo_select = IDX_W'($urandom_range(0, 3));
    // usual servo range, full range, edge values, or values at and just above the slot
    if (roll < 50)      w.target_position = POS_W'($urandom_range(500, 2500));
    else if (roll < 80) w.target_position = POS_W'($urandom_range(0, 32767));
    else if (roll < 87) w.target_position = '0;
    else if (roll < 94) w.target_position = '1;
    else                w.target_position = sb.slot[POS_W-1:0] + POS_W'($urandom_range(0, 2));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // cfg_we stays high across a batch; the caller lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int phase);
    case (phase)
      0: begin
        // frozen servo, max slew with a masked top bit, zero slot
        cfg_write(REG_SLEW_0, 16'h0000);
        cfg_write(REG_SLEW_1, 16'hFFFF);
        cfg_write(REG_SLEW_2, 16'h0001);
        cfg_write(REG_SLEW_3, 16'h7FFF);
        cfg_write(REG_SLOT_PERIOD, 16'h0000);
        cfg_write(REG_SPARE_5, 16'hFFFF);
        cfg_write(REG_SPARE_7, 16'h1234);
      end
      1: begin
        for (int i = 0; i < STEP_REGS; i++)
          cfg_write(CFG_IDX_W'(REG_SLEW_0 + i), CFG_DATA_W'($urandom_range(0, 65535)));
        cfg_write(REG_SLOT_PERIOD, 16'hFFFF);
      end
      default: begin
        for (int i = 0; i < STEP_REGS; i++)
          cfg_write(CFG_IDX_W'(REG_SLEW_0 + i), CFG_DATA_W'($urandom_range(0, 600)));
        cfg_write(REG_SLOT_PERIOD, CFG_DATA_W'($urandom_range(1000, 20000)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: frame at reset values, extreme targets, slewing back
    repeat (8) send_word(tick_word());
    send_word(target_word(2'd0, 15'h0000));
    send_word(target_word(2'd1, 15'h7FFF));
    send_word(target_word(2'd2, 15'h5555));
    send_word(target_word(2'd3, 15'h2AAA));
    repeat (8) send_word(tick_word());
    send_word(target_word(2'd0, 15'h7FFF));
    repeat (3) send_word(tick_word());

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      configure(phase);
      if (phase < 2) begin
        send_pct = 33;
        recv_pct = 81;
      end else if (phase < 4) begin
        send_pct = 81;
        recv_pct = 33;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      if (phase == 4) hold_go = 1'b1;
      repeat (PHASE_WORDS) send_word(random_word());
    end

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
